>>> hdl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Item types and function codes shared by the polyphase interpolator files.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned FRAC_W   = 15;

  typedef struct packed {
    logic                       func;
    logic [5:0]                 coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
  } ppi_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic [1:0]                 phase_number;
    logic                       last_of_run;
  } ppi_out_t;

  // one tap of the complex multiply-accumulate
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ppi_mac_ctrl_t;

endpackage

>>> hdl/polyphase_interpolator_unit.sv
// ----------------------------------------------------------------------------
// polyphase_interpolator_unit
// Complex polyphase FIR interpolator built around one shared complex MAC.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): a coefficient item
// (func = 0) stores one prototype tap by flat index; an index at or beyond
// UP_FACTOR*TAPS_PER_PHASE is dropped. A sample item (func = 1) enters the
// delay ring and starts a run of UP_FACTOR result items, one per branch, in
// branch order, the last one flagged.
// Output channel (out_valid_o / out_stall_i / out_item_o): each result is
// held in an output register until taken; a stall simply holds the branch
// sequencer, nothing is lost.
// Each branch feeds TAPS_PER_PHASE taps through the shared MAC and its read,
// multiply, accumulate and gain pipeline, then holds its result in the output
// stage; a stalled output holds the branch. The input is stalled for the
// whole run and reopens once the last result of the run is taken, so a new
// sample item is not taken before the previous run is through.
// After reset a clearing pass zeroes the coefficient and sample memories;
// the input is stalled meanwhile.
// ----------------------------------------------------------------------------
module polyphase_interpolator_unit import ppi_pkg::*; #(
  parameter int unsigned UP_FACTOR      = 4,
  parameter int unsigned TAPS_PER_PHASE = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ppi_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ppi_out_t out_item_o
);

  localparam int unsigned NUM_TAPS = UP_FACTOR * TAPS_PER_PHASE;
  localparam int unsigned CAW      = $clog2(NUM_TAPS);
  localparam int unsigned RAW      = $clog2(TAPS_PER_PHASE);
  localparam int unsigned PW       = $clog2(UP_FACTOR);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [CAW-1:0] clr_q, clr_d;
  logic [RAW-1:0] wp_q, wp_d;
  logic [RAW-1:0] pos_q, pos_d;
  logic [RAW-1:0] tap_q, tap_d;
  logic [CAW-1:0] caddr_q, caddr_d;
  logic [PW-1:0]  phase_q, phase_d;
  logic [1:0]     phase_ext;
  logic           in_acc, out_acc, last_tap, last_phase;

  // memories
  logic signed [SAMPLE_W-1:0]   coef_mem [NUM_TAPS];
  logic [2*SAMPLE_W-1:0]        ring_mem [TAPS_PER_PHASE];
  logic                         cw_en, rw_en;
  logic [CAW-1:0]               cw_addr;
  logic signed [SAMPLE_W-1:0]   cw_data;
  logic [RAW-1:0]               rw_addr;
  logic [2*SAMPLE_W-1:0]        rw_data;
  logic signed [SAMPLE_W-1:0]   coef_rd_q;
  logic [2*SAMPLE_W-1:0]        ring_rd_q;
  ppi_mac_ctrl_t                rd_ctrl_q, rd_ctrl_d;

  logic                         mac_done;
  logic signed [SAMPLE_W-1:0]   mac_re, mac_im;
  ppi_out_t                     out_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign last_tap    = (tap_q == RAW'(TAPS_PER_PHASE - 1));
  assign last_phase  = (phase_q == PW'(UP_FACTOR - 1));
  assign phase_ext   = 2'(phase_q);

  // memory write ports: clearing pass, coefficient item, sample item
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = clr_q;
    cw_data = '0;
    rw_en   = 1'b0;
    rw_addr = RAW'(clr_q);
    rw_data = '0;
    if (state_q == ST_CLEAR) begin
      cw_en = 1'b1;
      rw_en = (32'(clr_q) < TAPS_PER_PHASE);
    end else if (in_acc && in_item_i.func == FUNC_COEF) begin
      cw_en   = (32'(in_item_i.coef_index) < NUM_TAPS);
      cw_addr = CAW'(in_item_i.coef_index);
      cw_data = in_item_i.coef_value;
    end else if (in_acc && in_item_i.func == FUNC_SAMPLE) begin
      rw_en   = 1'b1;
      rw_addr = wp_q;
      rw_data = {in_item_i.sample_re, in_item_i.sample_im};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      coef_mem[cw_addr] <= cw_data;
    end
    coef_rd_q <= coef_mem[caddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      ring_mem[rw_addr] <= rw_data;
    end
    ring_rd_q <= ring_mem[pos_q];
  end

  // branch sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wp_d      = wp_q;
    pos_d     = pos_q;
    tap_d     = tap_q;
    caddr_d   = caddr_q;
    phase_d   = phase_q;
    rd_ctrl_d = '0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CAW'(1);
        if (clr_q == CAW'(NUM_TAPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_item_i.func == FUNC_SAMPLE) begin
          pos_d   = wp_q;
          tap_d   = '0;
          caddr_d = '0;
          phase_d = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_ctrl_d.valid = 1'b1;
        rd_ctrl_d.first = (tap_q == '0);
        rd_ctrl_d.last  = last_tap;
        pos_d   = (pos_q == '0) ? RAW'(TAPS_PER_PHASE - 1) : pos_q - RAW'(1);
        caddr_d = caddr_q + CAW'(UP_FACTOR);
        tap_d   = tap_q + RAW'(1);
        if (last_tap) begin
          tap_d   = '0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_phase) begin
            wp_d    = (wp_q == RAW'(TAPS_PER_PHASE - 1)) ? '0 : wp_q + RAW'(1);
            state_d = ST_IDLE;
          end else begin
            phase_d = phase_q + PW'(1);
            pos_d   = wp_q;
            caddr_d = CAW'(phase_q) + CAW'(1);
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      wp_q      <= '0;
      pos_q     <= '0;
      tap_q     <= '0;
      caddr_q   <= '0;
      phase_q   <= '0;
      rd_ctrl_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wp_q      <= wp_d;
      pos_q     <= pos_d;
      tap_q     <= tap_d;
      caddr_q   <= caddr_d;
      phase_q   <= phase_d;
      rd_ctrl_q <= rd_ctrl_d;
    end
  end

  ppi_cmac #(
    .UP_FACTOR      (UP_FACTOR),
    .TAPS_PER_PHASE (TAPS_PER_PHASE)
  ) u_cmac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rd_ctrl_q),
    .samp_re_i ($signed(ring_rd_q[2*SAMPLE_W-1:SAMPLE_W])),
    .samp_im_i ($signed(ring_rd_q[SAMPLE_W-1:0])),
    .coef_i    (coef_rd_q),
    .done_o    (mac_done),
    .res_re_o  (mac_re),
    .res_im_o  (mac_im)
  );

  // output register, loaded once per branch
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && mac_done) begin
      out_q.out_re       <= mac_re;
      out_q.out_im       <= mac_im;
      out_q.phase_number <= phase_ext;
      out_q.last_of_run  <= last_phase;
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_WAIT)
    else $error("mac result outside wait state");

  a_rd_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctrl_q.valid |-> (state_q == ST_RUN || state_q == ST_WAIT))
    else $error("memory read issued outside a branch run");

  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_q.last_of_run) |=> (wp_q != $past(wp_q) && state_q == ST_IDLE))
    else $error("write pointer did not advance at end of run");

  a_tap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_OUT) |-> tap_q == '0)
    else $error("tap counter not rewound between branches");

endmodule

>>> hdl/ppi_cmac.sv
// ----------------------------------------------------------------------------
// ppi_cmac
// Shared complex-by-real multiply-accumulate with gain, shift and saturation.
// ----------------------------------------------------------------------------
module ppi_cmac import ppi_pkg::*; #(
  parameter int unsigned UP_FACTOR      = 4,
  parameter int unsigned TAPS_PER_PHASE = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppi_mac_ctrl_t              ctrl_i,
  input  logic signed [SAMPLE_W-1:0] samp_re_i,
  input  logic signed [SAMPLE_W-1:0] samp_im_i,
  input  logic signed [SAMPLE_W-1:0] coef_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] res_re_o,
  output logic signed [SAMPLE_W-1:0] res_im_o
);

  localparam int unsigned ACC_W = PROD_W + $clog2(TAPS_PER_PHASE) + 1;
  localparam int unsigned SC_W  = ACC_W + $clog2(UP_FACTOR) + 1;
  localparam logic signed [SC_W-1:0] GAIN  = SC_W'(UP_FACTOR);
  localparam logic signed [SC_W-1:0] MAX_V = SC_W'(32767);
  localparam logic signed [SC_W-1:0] MIN_V = -SC_W'(32768);

  ppi_mac_ctrl_t            s1_q;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic                     s2_last_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic                     done_q;
  logic signed [SC_W-1:0]   sc_re_q, sc_im_q;
  logic signed [SC_W-1:0]   sh_re, sh_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      s1_q      <= ctrl_i;
      s2_last_q <= s1_q.valid & s1_q.last;
      done_q    <= s2_last_q;
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_re_q <= samp_re_i * coef_i;
      prod_im_q <= samp_im_i * coef_i;
    end
  end

  // stage 2: accumulate
  always_comb begin
    acc_re_d = s1_q.first ? ACC_W'(prod_re_q) : acc_re_q + ACC_W'(prod_re_q);
    acc_im_d = s1_q.first ? ACC_W'(prod_im_q) : acc_im_q + ACC_W'(prod_im_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  // stage 3: interpolation gain
  always_ff @(posedge clk_i) begin
    if (s2_last_q) begin
      sc_re_q <= SC_W'(acc_re_q) * GAIN;
      sc_im_q <= SC_W'(acc_im_q) * GAIN;
    end
  end

  // floor shift then clamp to 16 bits
  always_comb begin
    sh_re = sc_re_q >>> FRAC_W;
    sh_im = sc_im_q >>> FRAC_W;
    if (sh_re > MAX_V)      res_re_o = 16'sh7fff;
    else if (sh_re < MIN_V) res_re_o = 16'sh8000;
    else                    res_re_o = SAMPLE_W'(sh_re);
    if (sh_im > MAX_V)      res_im_o = 16'sh7fff;
    else if (sh_im < MIN_V) res_im_o = 16'sh8000;
    else                    res_im_o = SAMPLE_W'(sh_im);
  end

  assign done_o = done_q;

endmodule
